// ===== rtl/sorted_priority_list_unit_macros.svh =====
// Assertion macros used by the checker file of the priority list unit.
`ifndef SORTED_PRIORITY_LIST_UNIT_MACROS_SVH
`define SORTED_PRIORITY_LIST_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define SPL_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define SPL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/spl_pkg.sv =====
// Shared types and constants of the sorted priority list unit.
package spl_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int Q_DEPTH      = 2;
	localparam int VAL_W        = 32;
	localparam int PRI_W        = 8;

	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_SWAP   = 2'd1;
	localparam logic [1:0] KIND_DUMP   = 2'd2;

	typedef enum logic [1:0] {
		OP_INSERT,
		OP_SWAP,
		OP_SWAP_SAME,
		OP_DUMP
	} op_t;

	typedef enum logic [2:0] {
		STAT_INSERTED  = 3'd0,
		STAT_FULL      = 3'd1,
		STAT_SWAPPED   = 3'd2,
		STAT_SAME      = 3'd3,
		STAT_NOT_FOUND = 3'd4,
		STAT_DUMP      = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SWAP,
		S_DUMP
	} state_t;

	typedef enum logic [1:0] {
		C_HOLD,
		C_INSERT,
		C_SWAP,
		C_ROTATE
	} cell_op_t;

	typedef struct packed {
		op_t                      op;
		logic signed [VAL_W-1:0]  value;
		logic        [PRI_W-1:0]  p1;
		logic        [PRI_W-1:0]  p2;
	} cmd_t;

	typedef struct packed {
		status_t                  status;
		logic signed [VAL_W-1:0]  value;
		logic        [PRI_W-1:0]  prio;
		logic                     entry_valid;
		logic                     last;
	} res_t;

endpackage

// ===== rtl/spl_front.sv =====
// Front end: takes items off the command port and classifies them.
module spl_front
	import spl_pkg::*;
(
	input  logic                     start,
	input  logic [1:0]               kind,
	input  logic signed [VAL_W-1:0]  item_value,
	input  logic [PRI_W-1:0]         item_priority,
	input  logic [PRI_W-1:0]         other_priority,
	input  logic                     q_full,
	output logic                     busy,
	output logic                     push,
	output cmd_t                     cmd
);

	logic known;

	assign busy = q_full;

	always_comb begin
		cmd.value = item_value;
		cmd.p1    = item_priority;
		cmd.p2    = other_priority;
		cmd.op    = OP_INSERT;
		known     = 1'b1;
		unique case (kind)
			KIND_INSERT: cmd.op = OP_INSERT;
			// equal priorities are settled here, the list is never touched
			KIND_SWAP:   cmd.op = (item_priority == other_priority) ? OP_SWAP_SAME : OP_SWAP;
			KIND_DUMP:   cmd.op = OP_DUMP;
			default:     known  = 1'b0;
		endcase
	end

	// unknown kinds are accepted and dropped
	assign push = start && !q_full && known;

endmodule

// ===== rtl/spl_queue.sv =====
// Short command queue between the front end and the list engine.
module spl_queue
	import spl_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output cmd_t head,
	output logic empty,
	output logic full
);

	localparam int AW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int CW = $clog2(Q_DEPTH + 1);

	cmd_t            mem_q [Q_DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   cnt_q;
	logic            do_push;
	logic            do_pop;

	assign empty   = (cnt_q == '0);
	assign full    = (cnt_q == CW'(Q_DEPTH));
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			if (do_push && !do_pop)
				cnt_q <= cnt_q + CW'(1);
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_cmd;
	end

endmodule

// ===== rtl/spl_list.sv =====
// List engine: sorted cell array with insert, swap and rotating dump.
module spl_list
	import spl_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  cmd_t head,
	input  logic empty,
	output logic pop,
	output logic res_valid,
	output res_t res
);

	localparam int CW = $clog2(CAPACITY + 1);

	logic signed [VAL_W-1:0] val_q [CAPACITY];
	logic        [PRI_W-1:0] pri_q [CAPACITY];
	logic signed [VAL_W-1:0] val_d [CAPACITY];
	logic        [PRI_W-1:0] pri_d [CAPACITY];

	logic [CW-1:0]       count_q;
	logic [CW-1:0]       dump_idx_q;
	logic [CW-1:0]       last_idx;
	state_t              state_q, state_d;
	cell_op_t            cop;
	logic [CAPACITY-1:0] in_list, lt, first_a, first_b;
	logic [CAPACITY-1:0] fa_q, fb_q;
	logic signed [VAL_W-1:0] va, vb;
	logic                mark_ld, count_inc, dump_clr, dump_inc;
	logic                res_valid_d;
	res_t                res_d;
	logic                res_valid_q;
	res_t                res_q;

	assign last_idx = count_q - CW'(1);

	// per-cell compares; the list is sorted, so the first holder of a
	// priority is the cell whose left neighbor holds a different one
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cmp
		assign in_list[i] = (CW'(i) < count_q);
		assign lt[i]      = in_list[i] && (pri_q[i] < head.p1);
		if (i == 0) begin : g_first
			assign first_a[i] = in_list[i] && (pri_q[i] == head.p1);
			assign first_b[i] = in_list[i] && (pri_q[i] == head.p2);
		end else begin : g_rest
			assign first_a[i] = in_list[i] && (pri_q[i] == head.p1)
				&& (pri_q[i-1] != head.p1);
			assign first_b[i] = in_list[i] && (pri_q[i] == head.p2)
				&& (pri_q[i-1] != head.p2);
		end
	end

	// one-hot select of the two swap values
	always_comb begin
		va = '0;
		vb = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			va = va | (fa_q[i] ? val_q[i] : '0);
			vb = vb | (fb_q[i] ? val_q[i] : '0);
		end
	end

	always_comb begin
		state_d          = state_q;
		pop              = 1'b0;
		cop              = C_HOLD;
		mark_ld          = 1'b0;
		count_inc        = 1'b0;
		dump_clr         = 1'b0;
		dump_inc         = 1'b0;
		res_valid_d      = 1'b0;
		res_d.status     = STAT_INSERTED;
		res_d.value      = '0;
		res_d.prio       = '0;
		res_d.entry_valid = 1'b0;
		res_d.last       = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				if (!empty) begin
					pop = 1'b1;
					unique case (head.op)
						OP_INSERT: begin
							res_valid_d = 1'b1;
							if (count_q == CW'(CAPACITY)) begin
								res_d.status = STAT_FULL;
							end else begin
								cop       = C_INSERT;
								count_inc = 1'b1;
							end
						end
						OP_SWAP_SAME: begin
							res_valid_d  = 1'b1;
							res_d.status = STAT_SAME;
						end
						OP_SWAP: begin
							mark_ld = 1'b1;
							state_d = S_SWAP;
						end
						OP_DUMP: begin
							if (count_q == '0) begin
								res_valid_d  = 1'b1;
								res_d.status = STAT_DUMP;
							end else begin
								dump_clr = 1'b1;
								state_d  = S_DUMP;
							end
						end
					endcase
				end
			end
			S_SWAP: begin
				res_valid_d = 1'b1;
				state_d     = S_IDLE;
				if (|fa_q && |fb_q) begin
					cop          = C_SWAP;
					res_d.status = STAT_SWAPPED;
				end else begin
					res_d.status = STAT_NOT_FOUND;
				end
			end
			S_DUMP: begin
				// head cell goes out, the list rotates by one
				res_valid_d       = 1'b1;
				res_d.status      = STAT_DUMP;
				res_d.value       = val_q[0];
				res_d.prio        = pri_q[0];
				res_d.entry_valid = 1'b1;
				res_d.last        = (dump_idx_q == last_idx);
				cop               = C_ROTATE;
				dump_inc          = 1'b1;
				if (dump_idx_q == last_idx)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		always_comb begin
			val_d[i] = val_q[i];
			pri_d[i] = pri_q[i];
			case (cop)
				C_INSERT: begin
					if (!lt[i]) begin
						if (i == 0 || lt[(i == 0) ? 0 : i-1]) begin
							val_d[i] = head.value;
							pri_d[i] = head.p1;
						end else begin
							val_d[i] = val_q[(i == 0) ? 0 : i-1];
							pri_d[i] = pri_q[(i == 0) ? 0 : i-1];
						end
					end
				end
				C_SWAP: begin
					if (fa_q[i])
						val_d[i] = vb;
					else if (fb_q[i])
						val_d[i] = va;
				end
				C_ROTATE: begin
					if (CW'(i) == last_idx) begin
						val_d[i] = val_q[0];
						pri_d[i] = pri_q[0];
					end else if (i < CAPACITY - 1) begin
						val_d[i] = val_q[(i < CAPACITY - 1) ? i+1 : i];
						pri_d[i] = pri_q[(i < CAPACITY - 1) ? i+1 : i];
					end
				end
				default: ;
			endcase
		end

		always_ff @(posedge clk) begin
			val_q[i] <= val_d[i];
			pri_q[i] <= pri_d[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			dump_idx_q  <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			res_valid_q <= res_valid_d;
			if (count_inc)
				count_q <= count_q + CW'(1);
			if (dump_clr)
				dump_idx_q <= '0;
			else if (dump_inc)
				dump_idx_q <= dump_idx_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (mark_ld) begin
			fa_q <= first_a;
			fb_q <= first_b;
		end
		if (res_valid_d)
			res_q <= res_d;
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// ===== rtl/sorted_priority_list_unit.sv =====
// Insert is done from the idle state; swap marks both cells, then swaps; dump sends one entry per cycle.
// Commands go through the queue, the swap or dump state if any, and the result register;
// a 2-deep command queue lets start be taken while the engine works, busy only when it is full.
// Insert and swap use the parallel compares of the cells; dump uses the one-step rotation.
// Reset clears the entry count, queue, sequencer and result strobe; cell contents are kept.
// Results cannot be stalled: each shows for exactly one cycle with result_valid.
module sorted_priority_list_unit
	import spl_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [1:0]               kind,
	input  logic signed [VAL_W-1:0]  item_value,
	input  logic [PRI_W-1:0]         item_priority,
	input  logic [PRI_W-1:0]         other_priority,
	output logic                     result_valid,
	output logic [2:0]               status,
	output logic signed [VAL_W-1:0]  out_value,
	output logic [PRI_W-1:0]         out_priority,
	output logic                     entry_valid,
	output logic                     last
);

	cmd_t push_cmd;
	cmd_t head;
	logic push, pop, q_empty, q_full;
	res_t res;

	spl_front u_front (
		.start          (start),
		.kind           (kind),
		.item_value     (item_value),
		.item_priority  (item_priority),
		.other_priority (other_priority),
		.q_full         (q_full),
		.busy           (busy),
		.push           (push),
		.cmd            (push_cmd)
	);

	spl_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.empty    (q_empty),
		.full     (q_full)
	);

	spl_list #(
		.CAPACITY (CAPACITY)
	) u_list (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (q_empty),
		.pop       (pop),
		.res_valid (result_valid),
		.res       (res)
	);

	assign status       = res.status;
	assign out_value    = res.value;
	assign out_priority = res.prio;
	assign entry_valid  = res.entry_valid;
	assign last         = res.last;

endmodule

// ===== rtl/spl_checker.sv =====
// Port-level checker of the priority list unit, bound to the top level.
`include "sorted_priority_list_unit_macros.svh"

module spl_checker
	import spl_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              result_valid,
	input logic [2:0]        status,
	input logic [PRI_W-1:0]  out_priority,
	input logic              entry_valid,
	input logic              last
);

	// a status-only result is always the whole answer
	`SPL_ASSERT_SAME(a_status_single, result_valid && !entry_valid, last, "status result not last")
	`SPL_ASSERT_SAME(a_entry_is_dump, result_valid && entry_valid, status == STAT_DUMP, "entry without dump status")
	// a dump streams without gaps until its last entry
	`SPL_ASSERT_NEXT(a_dump_burst, result_valid && !last, result_valid && entry_valid, "gap in dump")
	`SPL_ASSERT_NEXT(a_dump_sorted, result_valid && entry_valid && !last, out_priority >= $past(out_priority), "dump out of order")

endmodule

bind sorted_priority_list_unit spl_checker u_chk (.*);
